// ===== design/sodrf_pkg.sv =====
// Shared types, widths and constants of the send-on-delta report filter.
`timescale 1ns / 1ps
`default_nettype none

package sodrf_pkg;

    // Field widths
    localparam int SAMPLE_W   = 12;
    localparam int TEMP_W     = 15;
    localparam int TTHR_W     = 14;
    localparam int PCT_W      = 7;
    localparam int CNT_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    // Divider sizing: the quotient never exceeds 100, so seven quotient bits
    localparam int DIV_STEPS = PCT_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int DIVD_W    = SAMPLE_W + PCT_W;

    localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(255);

    // Register reset values
    localparam logic [SAMPLE_W-1:0] AIR_RST    = SAMPLE_W'(3500);
    localparam logic [SAMPLE_W-1:0] WATER_RST  = SAMPLE_W'(1500);
    localparam logic [TTHR_W-1:0]   TTHR_RST   = TTHR_W'(200);
    localparam logic [PCT_W-1:0]    MTHR_RST   = PCT_W'(10);
    localparam logic [CNT_W-1:0]    PERIOD_RST = CNT_W'(5);

    // Register indexes on the write port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AIR_LEVEL          = 3'd0,
        CFG_WATER_LEVEL        = 3'd1,
        CFG_TEMP_THRESHOLD     = 3'd2,
        CFG_MOISTURE_THRESHOLD = 3'd3,
        CFG_REPORT_PERIOD      = 3'd4
    } t_cfg_idx;

    // Report cause codes
    typedef enum logic [1:0] {
        CAUSE_NONE   = 2'd0,
        CAUSE_PERIOD = 2'd1,
        CAUSE_TEMP   = 2'd2,
        CAUSE_MOIST  = 2'd3
    } t_cause;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_DECIDE
    } t_state;

    typedef struct packed {
        logic [SAMPLE_W-1:0] air_level;
        logic [SAMPLE_W-1:0] water_level;
        logic [TTHR_W-1:0]   temp_threshold;
        logic [PCT_W-1:0]    moisture_threshold;
        logic [CNT_W-1:0]    report_period;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic prep;
        logic div_step;
        logic commit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic skip;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== design/send_on_delta_report_filter.sv =====
// An input beat is captured in the idle state and goes through a prepare step; unless the
// percentage is clamped (0, 100 or bad calibration), it then goes through the 7-step divider.
// A new beat is taken only when idle, so an event is accepted only after the last one is committed;
// a waiting output beat holds the controller in its decision step and blocks input.
// Reset (synchronous, active low) restores register defaults, clears the wake counter,
// the last reported temperature and moisture and the output valid, and holds tready low.
`timescale 1ns / 1ps
`default_nettype none

module send_on_delta_report_filter (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // input stream
    input  wire                                  i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  wire  [31:0]                          i_s_axis_tdata,  // [14:0] temperature_centi,
                                                                  // [26:15] moisture_sample
    // output stream
    output logic                                 o_m_axis_tvalid,
    input  wire                                  i_m_axis_tready,
    output logic [7:0]                           o_m_axis_tdata,  // [6:0] moisture_percent
    output logic [2:0]                           o_m_axis_tuser,  // [0] transmit,
                                                                  // [2:1] trigger_cause
    // configuration
    input  wire                                  i_cfg_we,
    input  wire  [sodrf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [sodrf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int TW = sodrf_pkg::TEMP_W;
    localparam int SW = sodrf_pkg::SAMPLE_W;
    localparam int PW = sodrf_pkg::PCT_W;

    sodrf_pkg::t_cfg    cfg;
    sodrf_pkg::t_cmd    cmd;
    sodrf_pkg::t_status status;
    logic               out_transmit;
    logic [1:0]         out_cause;
    logic [PW-1:0]      out_pct;

    sodrf_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    sodrf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sodrf_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_temp     (i_s_axis_tdata[TW-1:0]),
        .i_sample   (i_s_axis_tdata[TW+SW-1:TW]),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_transmit (out_transmit),
        .o_cause    (out_cause),
        .o_pct      (out_pct)
    );

    // Pack the result beat
    assign o_m_axis_tdata = {1'b0, out_pct};
    assign o_m_axis_tuser = {out_cause, out_transmit};

endmodule

`default_nettype wire

// ===== design/sodrf_cfg.sv =====
// Configuration register file of the report filter.
`timescale 1ns / 1ps
`default_nettype none

module sodrf_cfg (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire  [sodrf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [sodrf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output sodrf_pkg::t_cfg                      o_cfg
);

    sodrf_pkg::t_cfg r_cfg;

    // Write the addressed register; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.air_level          <= sodrf_pkg::AIR_RST;
            r_cfg.water_level        <= sodrf_pkg::WATER_RST;
            r_cfg.temp_threshold     <= sodrf_pkg::TTHR_RST;
            r_cfg.moisture_threshold <= sodrf_pkg::MTHR_RST;
            r_cfg.report_period      <= sodrf_pkg::PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (sodrf_pkg::t_cfg_idx'(i_cfg_idx))
                sodrf_pkg::CFG_AIR_LEVEL:
                    r_cfg.air_level <= i_cfg_data[sodrf_pkg::SAMPLE_W-1:0];
                sodrf_pkg::CFG_WATER_LEVEL:
                    r_cfg.water_level <= i_cfg_data[sodrf_pkg::SAMPLE_W-1:0];
                sodrf_pkg::CFG_TEMP_THRESHOLD:
                    r_cfg.temp_threshold <= i_cfg_data[sodrf_pkg::TTHR_W-1:0];
                sodrf_pkg::CFG_MOISTURE_THRESHOLD:
                    r_cfg.moisture_threshold <= i_cfg_data[sodrf_pkg::PCT_W-1:0];
                sodrf_pkg::CFG_REPORT_PERIOD:
                    r_cfg.report_period <= i_cfg_data[sodrf_pkg::CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== design/sodrf_ctrl.sv =====
// Sequencing state machine of the report filter.
`timescale 1ns / 1ps
`default_nettype none

module sodrf_ctrl (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  sodrf_pkg::t_status     i_status,
    output sodrf_pkg::t_cmd        o_cmd
);

    sodrf_pkg::t_state               r_state, n_state;
    logic [sodrf_pkg::STEP_W-1:0]    r_step, n_step;

    // State and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sodrf_pkg::ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            sodrf_pkg::ST_IDLE: begin
                // take no beat while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = sodrf_pkg::ST_PREP;
                end
            end
            sodrf_pkg::ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_step     = '0;
                n_state    = i_status.skip ? sodrf_pkg::ST_DECIDE : sodrf_pkg::ST_DIV;
            end
            sodrf_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == sodrf_pkg::STEP_W'(sodrf_pkg::DIV_STEPS - 1)) begin
                    n_state = sodrf_pkg::ST_DECIDE;
                end
            end
            sodrf_pkg::ST_DECIDE: begin
                // hold until the output register can take the beat
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = sodrf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sodrf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/sodrf_dpath.sv =====
// Datapath of the report filter: percentage divider, report decision, output register.
`timescale 1ns / 1ps
`default_nettype none

module sodrf_dpath (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  sodrf_pkg::t_cfg                      i_cfg,
    input  sodrf_pkg::t_cmd                      i_cmd,
    output sodrf_pkg::t_status                   o_status,
    input  wire  signed [sodrf_pkg::TEMP_W-1:0]  i_temp,
    input  wire  [sodrf_pkg::SAMPLE_W-1:0]       i_sample,
    output logic                                 o_valid,
    input  wire                                  i_ready,
    output logic                                 o_transmit,
    output logic [1:0]                           o_cause,
    output logic [sodrf_pkg::PCT_W-1:0]          o_pct
);

    localparam int TW = sodrf_pkg::TEMP_W;
    localparam int SW = sodrf_pkg::SAMPLE_W;
    localparam int PW = sodrf_pkg::PCT_W;
    localparam int DW = sodrf_pkg::DIVD_W;
    localparam int CW = sodrf_pkg::CNT_W;

    // Captured event
    logic signed [TW-1:0] r_temp;
    logic [SW-1:0]        r_sample;

    // Divider
    logic [DW-1:0] r_dvd, r_dvs;
    logic [PW-1:0] r_q;

    // Report state
    logic [CW-1:0]        r_cnt;
    logic signed [TW-1:0] r_last_temp;
    logic [PW-1:0]        r_last_pct;

    // Output register
    logic          r_o_valid;
    logic          r_o_transmit;
    logic [1:0]    r_o_cause;
    logic [PW-1:0] r_o_pct;

    logic          cal_bad, above_air, below_wet;
    logic [PW-1:0] skip_pct;
    logic [SW-1:0] span, depth;
    logic [DW:0]   trial;

    logic [CW-1:0]        cnt_inc;
    logic signed [TW:0]   dt;
    logic [TW-1:0]        adt;
    logic [PW-1:0]        dm;
    sodrf_pkg::t_cause    cause;

    // Classify the sample against the calibration points
    always_comb begin
        cal_bad   = i_cfg.air_level <= i_cfg.water_level;
        above_air = r_sample > i_cfg.air_level;
        below_wet = r_sample < i_cfg.water_level;
        span      = i_cfg.air_level - i_cfg.water_level;
        depth     = i_cfg.air_level - r_sample;
        if (cal_bad || above_air) begin
            skip_pct = '0;
        end else begin
            skip_pct = sodrf_pkg::PCT_FULL;
        end
        trial = {1'b0, r_dvd} - {1'b0, r_dvs};
    end

    assign o_status.skip     = cal_bad || above_air || below_wet;
    assign o_status.out_free = !r_o_valid || i_ready;

    // Capture the event
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_temp   <= i_temp;
            r_sample <= i_sample;
        end
    end

    // Restoring divide, one quotient bit a cycle, most significant first
    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_dvd <= DW'(depth) * DW'(sodrf_pkg::PCT_FULL);
            r_dvs <= DW'(span) << (PW - 1);
            r_q   <= o_status.skip ? skip_pct : '0;
        end else if (i_cmd.div_step) begin
            if (!trial[DW]) begin
                r_dvd <= trial[DW-1:0];
            end
            r_q   <= {r_q[PW-2:0], !trial[DW]};
            r_dvs <= r_dvs >> 1;
        end
    end

    // Decide on a report, priority period, temperature, moisture
    always_comb begin
        cnt_inc = (r_cnt == sodrf_pkg::CNT_MAX) ? r_cnt : r_cnt + 1'b1;
        dt      = {r_temp[TW-1], r_temp} - {r_last_temp[TW-1], r_last_temp};
        adt     = dt[TW] ? TW'(-dt) : dt[TW-1:0];
        dm      = (r_q > r_last_pct) ? r_q - r_last_pct : r_last_pct - r_q;
        if (cnt_inc >= i_cfg.report_period) begin
            cause = sodrf_pkg::CAUSE_PERIOD;
        end else if (adt >= TW'(i_cfg.temp_threshold)) begin
            cause = sodrf_pkg::CAUSE_TEMP;
        end else if (dm >= i_cfg.moisture_threshold) begin
            cause = sodrf_pkg::CAUSE_MOIST;
        end else begin
            cause = sodrf_pkg::CAUSE_NONE;
        end
    end

    // Advance the counter; on a report clear it and remember the values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_last_temp <= '0;
            r_last_pct  <= '0;
        end else if (i_cmd.commit) begin
            if (cause != sodrf_pkg::CAUSE_NONE) begin
                r_cnt       <= '0;
                r_last_temp <= r_temp;
                r_last_pct  <= r_q;
            end else begin
                r_cnt <= cnt_inc;
            end
        end
    end

    // Output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_o_transmit <= cause != sodrf_pkg::CAUSE_NONE;
            r_o_cause    <= cause;
            r_o_pct      <= r_q;
        end
    end

    assign o_valid    = r_o_valid;
    assign o_transmit = r_o_transmit;
    assign o_cause    = r_o_cause;
    assign o_pct      = r_o_pct;

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for the send-on-delta report filter: stream driver, predictor, monitor.
`timescale 1ns / 1ps

module tb;
    import sodrf_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_PHASES = 14;
    localparam int PHASE_ITEMS   = 130;

    typedef struct {
        logic signed [TEMP_W-1:0] temp;
        logic [SAMPLE_W-1:0]      sample;
    } t_wake;

    typedef struct {
        logic             transmit;
        t_cause           cause;
        logic [PCT_W-1:0] pct;
    } t_report;

    // DUT connections
    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  s_valid  = 1'b0;
    logic [31:0]           s_data   = '0;
    logic                  m_ready  = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    wire                   s_ready;
    wire                   m_valid;
    wire  [7:0]            m_data;
    wire  [2:0]            m_user;

    // Predictor copy of the registers and the report state
    logic [SAMPLE_W-1:0]      cal_air    = AIR_RST;
    logic [SAMPLE_W-1:0]      cal_water  = WATER_RST;
    logic [TTHR_W-1:0]        temp_delta = TTHR_RST;
    logic [PCT_W-1:0]         moist_delta = MTHR_RST;
    logic [CNT_W-1:0]         heartbeat  = PERIOD_RST;
    logic [CNT_W-1:0]         wakes_since = '0;
    logic signed [TEMP_W-1:0] sent_temp  = '0;
    logic [PCT_W-1:0]         sent_pct   = '0;

    t_wake   wake_q[$];
    t_report pending_reports[$];
    t_wake   next_wake;
    t_report got_report;
    t_report want_report;

    bit in_taken   = 1'b0;
    int burst_left = 0;
    int gap_left   = 0;
    int rx_mode    = 0;
    int rx_left    = 0;
    int cycles     = 0;
    int drift_temp = 0;
    int drift_sample = 2048;

    int n_checked = 0;
    int n_fail    = 0;
    int n_period  = 0;
    int n_temp    = 0;
    int n_moist   = 0;
    int n_quiet   = 0;
    int n_setups  = 1;

    send_on_delta_report_filter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // [14:0] temperature_centi, [26:15] moisture_sample
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),   // [6:0] moisture_percent
        .o_m_axis_tuser  (m_user),   // [0] transmit, [2:1] trigger_cause
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Map a raw converter reading to percent under the current calibration
    function automatic logic [PCT_W-1:0] soil_percent(input logic [SAMPLE_W-1:0] sample);
        int air;
        int wet;
        int s;
        air = int'(cal_air);
        wet = int'(cal_water);
        s   = int'(sample);
        if (air <= wet)
            return '0;
        if (s > air)
            return '0;
        if (s < wet)
            return PCT_FULL;
        return PCT_W'(((air - s) * 100) / (air - wet));
    endfunction

    // Advance the report state for one wake event and queue the expected beat
    task automatic predict_report(input logic signed [TEMP_W-1:0] temp,
                                  input logic [SAMPLE_W-1:0] sample);
        logic [PCT_W-1:0] pct;
        int               dt;
        int               dm;
        t_report          r;
        pct = soil_percent(sample);
        if (wakes_since < CNT_MAX)
            wakes_since = wakes_since + 1'b1;
        dt = int'(temp) - int'(sent_temp);
        if (dt < 0)
            dt = -dt;
        dm = int'(pct) - int'(sent_pct);
        if (dm < 0)
            dm = -dm;
        if (wakes_since >= heartbeat)
            r.cause = CAUSE_PERIOD;
        else if (dt >= int'(temp_delta))
            r.cause = CAUSE_TEMP;
        else if (dm >= int'(moist_delta))
            r.cause = CAUSE_MOIST;
        else
            r.cause = CAUSE_NONE;
        if (r.cause != CAUSE_NONE) begin
            wakes_since = '0;
            sent_temp   = temp;
            sent_pct    = pct;
        end
        r.transmit = (r.cause != CAUSE_NONE);
        r.pct      = pct;
        pending_reports.push_back(r);
    endtask

    // Monitor: track register writes, predict on input beats, check output beats
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_we) begin
                case (t_cfg_idx'(cfg_idx))
                    CFG_AIR_LEVEL:          cal_air     = cfg_data[SAMPLE_W-1:0];
                    CFG_WATER_LEVEL:        cal_water   = cfg_data[SAMPLE_W-1:0];
                    CFG_TEMP_THRESHOLD:     temp_delta  = cfg_data[TTHR_W-1:0];
                    CFG_MOISTURE_THRESHOLD: moist_delta = cfg_data[PCT_W-1:0];
                    CFG_REPORT_PERIOD:      heartbeat   = cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                predict_report(s_data[TEMP_W-1:0], s_data[TEMP_W+SAMPLE_W-1:TEMP_W]);
            if (m_valid && m_ready) begin
                got_report.transmit = m_user[0];
                got_report.cause    = t_cause'(m_user[2:1]);
                got_report.pct      = m_data[PCT_W-1:0];
                if (pending_reports.size() == 0) begin
                    n_fail++;
                    $display("%0t: unexpected beat: transmit=%0b cause=%0d pct=%0d", $time,
                             got_report.transmit, got_report.cause, got_report.pct);
                end else begin
                    want_report = pending_reports.pop_front();
                    n_checked++;
                    case (want_report.cause)
                        CAUSE_PERIOD: n_period++;
                        CAUSE_TEMP:   n_temp++;
                        CAUSE_MOIST:  n_moist++;
                        default:      n_quiet++;
                    endcase
                    if (got_report.transmit !== want_report.transmit ||
                        got_report.cause !== want_report.cause ||
                        got_report.pct !== want_report.pct) begin
                        n_fail++;
                        $display("%0t: mismatch: expected transmit=%0b cause=%0d pct=%0d, actual transmit=%0b cause=%0d pct=%0d",
                                 $time, want_report.transmit, want_report.cause, want_report.pct,
                                 got_report.transmit, got_report.cause, got_report.pct);
                    end
                end
            end
        end
        in_taken = i_rst_n && s_valid && s_ready;
    end

    // Driver: send queued wake events in bursts separated by random gaps
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_valid || in_taken)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid  <= 1'b0;
            end else if (wake_q.size() != 0) begin
                next_wake = wake_q.pop_front();
                s_data  <= {5'b0, next_wake.sample, next_wake.temp};
                s_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: switch at random between stall patterns
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(20, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= $urandom_range(0, 1);
            2:       m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= (rx_left % 12) >= 5;
        endcase
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d reports outstanding", $time, pending_reports.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input int value);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic set_calibration(input int air, input int water, input int tthr,
                                   input int mthr, input int period);
        write_reg(CFG_AIR_LEVEL, air);
        write_reg(CFG_WATER_LEVEL, water);
        write_reg(CFG_TEMP_THRESHOLD, tthr);
        write_reg(CFG_MOISTURE_THRESHOLD, mthr);
        write_reg(CFG_REPORT_PERIOD, period);
        n_setups++;
    endtask

    // Wait until every queued event has produced its report, then let the block settle
    task automatic drain();
        while (wake_q.size() != 0 || s_valid || pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_wake(input int temp, input int sample);
        t_wake w;
        w.temp   = TEMP_W'(temp);
        w.sample = SAMPLE_W'(sample);
        wake_q.push_back(w);
    endtask

    // Mostly slow drift around the last reading, some jumps, a few raw field values
    task automatic queue_drift(input int count);
        int step;
        int roll;
        step = int'(temp_delta) * 3 / 2 + 10;
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 75) begin
                drift_temp   += int'($urandom_range(0, 2 * step)) - step;
                drift_sample += int'($urandom_range(0, 160)) - 80;
                if (drift_temp < -4000)  drift_temp = -4000;
                if (drift_temp > 8500)   drift_temp = 8500;
                if (drift_sample < 0)    drift_sample = 0;
                if (drift_sample > 4095) drift_sample = 4095;
                queue_wake(drift_temp, drift_sample);
            end else if (roll < 95) begin
                drift_temp   = int'($urandom_range(0, 12500)) - 4000;
                drift_sample = $urandom_range(0, 4095);
                queue_wake(drift_temp, drift_sample);
            end else begin
                queue_wake($urandom_range(0, 32767), $urandom_range(0, 4095));
            end
        end
    endtask

    task automatic random_calibration();
        int air;
        int water;
        int tthr;
        int mthr;
        int period;
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0)      air = 0;
        else if (roll < 3)  air = 4095;
        else                air = $urandom_range(500, 4095);
        roll = $urandom_range(0, 9);
        if (roll == 0)      water = $urandom_range(air, 4095);
        else if (roll == 1 || air == 0) water = 0;
        else                water = $urandom_range(0, air - 1);
        roll = $urandom_range(0, 9);
        if (roll == 0)      tthr = 0;
        else if (roll == 1) tthr = 12500;
        else if (roll < 6)  tthr = $urandom_range(1, 300);
        else                tthr = $urandom_range(300, 3000);
        roll = $urandom_range(0, 9);
        if (roll == 0)      mthr = 0;
        else if (roll == 1) mthr = 100;
        else                mthr = $urandom_range(1, 30);
        roll = $urandom_range(0, 9);
        if (roll == 0)      period = 255;
        else if (roll == 1) period = 1;
        else                period = $urandom_range(2, 25);
        set_calibration(air, water, tthr, mthr, period);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset calibration: quiet event, temperature, moisture and period causes,
        // clamps at both ends, field extremes
        queue_wake(0, 4095);
        queue_wake(199, 3500);
        queue_wake(-200, 3501);
        queue_wake(-200, 3300);
        queue_wake(-200, 1500);
        queue_wake(-200, 1499);
        queue_wake(-200, 0);
        queue_wake(-200, 0);
        queue_wake(-200, 0);
        queue_wake(-200, 0);
        queue_wake(-16384, 2501);
        queue_wake(16383, 2500);
        queue_wake(-4000, 1365);
        queue_wake(8500, 2730);
        queue_wake(8500, 2000);
        drain();

        // Widest span with zero period and zero thresholds: every event reports
        set_calibration(4095, 0, 0, 0, 0);
        queue_wake(-4000, 0);
        queue_wake(8500, 4095);
        queue_wake(0, 2048);
        drain();

        // Inverted calibration and maximum thresholds
        set_calibration(0, 4095, 12500, 100, 255);
        queue_wake(100, 2047);
        queue_wake(-4000, 0);
        queue_wake(8500, 4095);
        drain();

        // Equal calibration points
        set_calibration(2000, 2000, 50, 5, 3);
        queue_wake(0, 1999);
        queue_wake(0, 2000);
        queue_wake(0, 2001);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            random_calibration();
            queue_drift(PHASE_ITEMS);
            drain();
        end

        $display("Checked %0d reports over %0d calibration settings", n_checked, n_setups);
        $display("Causes seen: %0d period, %0d temperature, %0d moisture, %0d quiet",
                 n_period, n_temp, n_moist, n_quiet);
        if (n_fail == 0 && pending_reports.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/sodrf_pkg.sv
design/sodrf_cfg.sv
design/sodrf_ctrl.sv
design/sodrf_dpath.sv
design/send_on_delta_report_filter.sv
bench/tb.sv
